// ===== hw/rtl/mslc_pkg.sv =====
// shared types, constants and register codes of the street lamp controller
// no dependencies; used by every other file of the block but mslc_out_if
`default_nettype none

package mslc_pkg;

  // field and register widths
  localparam int CntW     = 16;
  localparam int TickW    = 16;
  localparam int ThrW     = 8;
  localparam int ActW     = 2;
  localparam int SampleW  = 12;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 16;
  localparam int CmpW     = (CntW > TickW) ? CntW : TickW;

  // action codes of an input beat
  localparam logic [ActW-1:0] ACT_TICK   = 2'd0;
  localparam logic [ActW-1:0] ACT_MOTION = 2'd1;
  localparam logic [ActW-1:0] ACT_SOUND  = 2'd2;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_SOUND_THR  = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_ON_TIMEOUT = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_SOUND_HOLD = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_IDLE_SLEEP = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_BLINK      = 3'd4;

  // configuration reset values
  localparam logic [ThrW-1:0]  RST_SOUND_THR  = 8'd230;
  localparam logic [TickW-1:0] RST_ON_TIMEOUT = 16'd250;
  localparam logic [TickW-1:0] RST_SOUND_HOLD = 16'd150;
  localparam logic [TickW-1:0] RST_IDLE_SLEEP = 16'd3000;
  localparam logic [TickW-1:0] RST_BLINK      = 16'd25;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_ON    = 2'd1,
    MODE_ALARM = 2'd2,
    MODE_SLEEP = 2'd3
  } mode_e;

  typedef struct packed {
    logic [ThrW-1:0]  sound_thr;
    logic [TickW-1:0] on_timeout;
    logic [TickW-1:0] sound_hold;
    logic [TickW-1:0] idle_sleep;
    logic [TickW-1:0] blink;
  } cfg_t;

  typedef struct packed {
    logic  lamp_on;
    mode_e mode;
    logic  status_led;
  } result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/mslc_in_if.sv =====
// input channel of the lamp controller: valid/ready plus action and sample
// depends on mslc_pkg for field widths
`default_nettype none

interface mslc_in_if;
  logic                          valid;
  logic                          ready;
  logic [mslc_pkg::ActW-1:0]    action;
  logic [mslc_pkg::SampleW-1:0] sample_value;

  modport source (output valid, action, sample_value, input ready);
  modport sink   (input valid, action, sample_value, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/mslc_out_if.sv =====
// result channel of the lamp controller: valid/ready plus lamp, mode and led
// no package dependency beyond plain widths
`default_nettype none

interface mslc_out_if;
  logic       valid;
  logic       ready;
  logic       lamp_on;
  logic [1:0] mode;
  logic       status_led;

  modport source (output valid, lamp_on, mode, status_led, input ready);
  modport sink   (input valid, lamp_on, mode, status_led, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/mslc_cfg.sv =====
// configuration register file of the lamp controller, plain write port
// depends on mslc_pkg for widths, indexes and reset values
`default_nettype none

module mslc_cfg (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           we_i,
  input  wire logic [mslc_pkg::CfgIdxW-1:0]  idx_i,
  input  wire logic [mslc_pkg::CfgDataW-1:0] data_i,
  output mslc_pkg::cfg_t                      cfg_o
);

  mslc_pkg::cfg_t cfg_q, cfg_d;

  // decode one register write
  always_comb begin
    cfg_d = cfg_q;
    if (we_i) begin
      unique case (idx_i)
        mslc_pkg::CFG_SOUND_THR:  cfg_d.sound_thr  = data_i[mslc_pkg::ThrW-1:0];
        mslc_pkg::CFG_ON_TIMEOUT: cfg_d.on_timeout = data_i[mslc_pkg::TickW-1:0];
        mslc_pkg::CFG_SOUND_HOLD: cfg_d.sound_hold = data_i[mslc_pkg::TickW-1:0];
        mslc_pkg::CFG_IDLE_SLEEP: cfg_d.idle_sleep = data_i[mslc_pkg::TickW-1:0];
        mslc_pkg::CFG_BLINK:      cfg_d.blink      = data_i[mslc_pkg::TickW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sound_thr  <= mslc_pkg::RST_SOUND_THR;
      cfg_q.on_timeout <= mslc_pkg::RST_ON_TIMEOUT;
      cfg_q.sound_hold <= mslc_pkg::RST_SOUND_HOLD;
      cfg_q.idle_sleep <= mslc_pkg::RST_IDLE_SLEEP;
      cfg_q.blink      <= mslc_pkg::RST_BLINK;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== hw/rtl/mslc_step.sv =====
// mode state, counters and event slot of the lamp controller with the
// single-pass update for one beat; depends on mslc_pkg
`default_nettype none

module mslc_step (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          step_i,
  input  wire mslc_pkg::cfg_t                cfg_i,
  input  wire logic [mslc_pkg::ActW-1:0]    action_i,
  input  wire logic [mslc_pkg::SampleW-1:0] sample_i,
  output mslc_pkg::result_t                  res_o
);

  typedef enum logic [2:0] {
    EV_NONE   = 3'd0,
    EV_TIMER  = 3'd1,
    EV_MOTION = 3'd2,
    EV_SOUND  = 3'd3,
    EV_SLEEP  = 3'd4
  } event_e;

  typedef logic [mslc_pkg::CntW-1:0] cnt_t;

  typedef struct packed {
    mslc_pkg::mode_e mode;
    event_e          ev;
    cnt_t            timeout_cnt;
    cnt_t            idle_cnt;
    cnt_t            hold_cnt;
    cnt_t            blink_cnt;
    logic            sound_recent;
    logic            blink_en;
    logic            lamp;
    logic            led;
  } st_t;

  st_t st_q, st_d;

  // saturating increment
  function automatic cnt_t bump(cnt_t c);
    return (c == '1) ? c : c + cnt_t'(1);
  endfunction

  // counter has reached its limit
  function automatic logic hit(cnt_t c, logic [mslc_pkg::TickW-1:0] lim);
    return mslc_pkg::CmpW'(c) >= mslc_pkg::CmpW'(lim);
  endfunction

  // timer and sleep overwrite the slot, others only fill an empty one
  function automatic event_e post(event_e slot, event_e e);
    if (e == EV_TIMER || e == EV_SLEEP) return e;
    return (slot == EV_NONE) ? e : slot;
  endfunction

  // leave the current mode and enter the next
  function automatic st_t go(st_t s, mslc_pkg::mode_e nxt);
    st_t r;
    r = s;
    if (s.mode == mslc_pkg::MODE_ON) begin
      r.led = 1'b0;
      if (nxt == mslc_pkg::MODE_IDLE) r.lamp = 1'b0;
    end else if (s.mode == mslc_pkg::MODE_ALARM) begin
      r.led      = 1'b0;
      r.blink_en = 1'b0;
      r.lamp     = 1'b0;
    end
    r.mode = nxt;
    unique case (nxt)
      mslc_pkg::MODE_IDLE: begin
        r.idle_cnt = '0;
        r.led      = 1'b1;
      end
      mslc_pkg::MODE_ON: begin
        r.idle_cnt    = '0;
        r.lamp        = 1'b1;
        r.timeout_cnt = '0;
      end
      mslc_pkg::MODE_ALARM: begin
        r.idle_cnt     = '0;
        r.sound_recent = 1'b0;
        r.hold_cnt     = '0;
        r.blink_en     = 1'b1;
        r.blink_cnt    = '0;
        r.timeout_cnt  = '0;
        r.lamp         = 1'b1;
      end
      mslc_pkg::MODE_SLEEP: begin
        r.lamp = 1'b0;
      end
    endcase
    return r;
  endfunction

  // one timer tick: timeout counter always, hold, blink and idle counters when active
  function automatic st_t tick(st_t s, mslc_pkg::cfg_t c);
    st_t r;
    r = s;
    r.timeout_cnt = bump(s.timeout_cnt);
    if (hit(r.timeout_cnt, c.on_timeout)) begin
      r.timeout_cnt = '0;
      r.ev          = post(r.ev, EV_TIMER);
    end
    if (s.sound_recent) begin
      r.hold_cnt = bump(s.hold_cnt);
      if (hit(r.hold_cnt, c.sound_hold)) begin
        r.hold_cnt     = '0;
        r.sound_recent = 1'b0;
      end
    end
    if (s.mode == mslc_pkg::MODE_ALARM && s.blink_en) begin
      r.blink_cnt = bump(s.blink_cnt);
      if (hit(r.blink_cnt, c.blink)) begin
        r.blink_cnt = '0;
        r.lamp      = ~s.lamp;
      end
    end
    if (s.mode == mslc_pkg::MODE_IDLE) begin
      r.idle_cnt = bump(s.idle_cnt);
      if (hit(r.idle_cnt, c.idle_sleep)) begin
        r.idle_cnt = '0;
        r.ev       = post(r.ev, EV_SLEEP);
      end
    end
    return r;
  endfunction

  // consume the pending event once
  function automatic st_t settle(st_t s);
    st_t r;
    r = s;
    unique case (s.mode)
      mslc_pkg::MODE_IDLE: begin
        r.led = 1'b1;
        if (s.ev == EV_MOTION) begin
          r.ev = EV_NONE;
          r    = go(r, s.sound_recent ? mslc_pkg::MODE_ALARM : mslc_pkg::MODE_ON);
        end else if (s.ev == EV_SOUND || s.ev == EV_TIMER) begin
          // stale events are dropped in idle
          r.ev = EV_NONE;
        end else if (s.ev == EV_SLEEP) begin
          r.ev = EV_NONE;
          r    = go(r, mslc_pkg::MODE_SLEEP);
        end
      end
      mslc_pkg::MODE_ON: begin
        if (s.ev == EV_MOTION) begin
          r.timeout_cnt = '0;
          r.ev          = EV_NONE;
        end else if (s.ev == EV_SOUND) begin
          r.ev = EV_NONE;
          r    = go(r, mslc_pkg::MODE_ALARM);
        end else if (s.ev == EV_TIMER) begin
          r.ev = EV_NONE;
          r    = go(r, mslc_pkg::MODE_IDLE);
        end
      end
      mslc_pkg::MODE_ALARM: begin
        if (s.ev == EV_MOTION) begin
          r.timeout_cnt = '0;
          r.ev          = EV_NONE;
        end else if (s.ev == EV_TIMER) begin
          r.ev = EV_NONE;
          r    = go(r, mslc_pkg::MODE_IDLE);
        end
      end
      mslc_pkg::MODE_SLEEP: ;
    endcase
    return r;
  endfunction

  // next state for the beat in the input register
  always_comb begin
    st_t s;
    s = st_q;
    if (st_q.mode == mslc_pkg::MODE_SLEEP) begin
      // only motion wakes the block
      if (action_i == mslc_pkg::ACT_MOTION) begin
        s.timeout_cnt = '0;
        s.mode        = mslc_pkg::MODE_IDLE;
        s.idle_cnt    = '0;
        s.led         = 1'b1;
      end
    end else begin
      unique case (action_i)
        mslc_pkg::ACT_TICK: s = tick(s, cfg_i);
        mslc_pkg::ACT_MOTION: begin
          s.led = 1'b1;
          s.ev  = post(s.ev, EV_MOTION);
        end
        mslc_pkg::ACT_SOUND: begin
          if (sample_i[mslc_pkg::SampleW-1 -: mslc_pkg::ThrW] > cfg_i.sound_thr) begin
            s.sound_recent = 1'b1;
            s.hold_cnt     = '0;
            if (st_q.mode != mslc_pkg::MODE_ALARM) s.ev = post(s.ev, EV_SOUND);
          end
        end
        default: ;
      endcase
      s = settle(s);
    end
    st_d = s;
  end

  // state register, updated once per beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.mode         <= mslc_pkg::MODE_IDLE;
      st_q.ev           <= EV_NONE;
      st_q.timeout_cnt  <= '0;
      st_q.idle_cnt     <= '0;
      st_q.hold_cnt     <= '0;
      st_q.blink_cnt    <= '0;
      st_q.sound_recent <= 1'b0;
      st_q.blink_en     <= 1'b0;
      st_q.lamp         <= 1'b0;
      st_q.led          <= 1'b0;
    end else if (step_i) begin
      st_q <= st_d;
    end
  end

  // result of this beat
  assign res_o.lamp_on    = st_d.lamp;
  assign res_o.mode       = st_d.mode;
  assign res_o.status_led = st_d.led;

endmodule

`default_nettype wire

// ===== hw/rtl/motion_sound_lamp_controller.sv =====
// top level of the street lamp controller: input register, state update and
// result register; depends on mslc_pkg, mslc_in_if, mslc_out_if, mslc_cfg, mslc_step
//
//   channel | dir | payload                        | handshake
//   in_i    | in  | action, sample_value           | valid/ready
//   out_o   | out | lamp_on, mode, status_led      | valid/ready
//   cfg     | in  | cfg_we_i, cfg_idx_i, cfg_data_i | write enable only
//
// a beat waits in the input register until the result register is free, the state update
// runs combinationally on it and the result is registered in the output register
// one beat per cycle sustained while the result channel is ready
// a stalled result holds the state update; the input register still takes one beat
// reset clears all valid flags and the mode state and loads the configuration defaults
`default_nettype none

module motion_sound_lamp_controller (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  mslc_in_if.sink                             in_i,
  mslc_out_if.source                          out_o,
  input  wire logic                           cfg_we_i,
  input  wire logic [mslc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [mslc_pkg::CfgDataW-1:0] cfg_data_i
);

  mslc_pkg::cfg_t    cfg;
  mslc_pkg::result_t res;

  logic                          in_vld_q, in_vld_d;
  logic [mslc_pkg::ActW-1:0]    action_q;
  logic [mslc_pkg::SampleW-1:0] sample_q;
  logic                          out_vld_q, out_vld_d;
  mslc_pkg::result_t             res_q;
  logic                          out_free;
  logic                          step;
  logic                          in_acc;

  // handshake control
  assign out_free = !out_vld_q || out_o.ready;
  assign step     = in_vld_q && out_free;
  assign in_i.ready = !in_vld_q || out_free;
  assign in_acc   = in_i.valid && in_i.ready;

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_acc) in_vld_d = 1'b1;
    else if (step) in_vld_d = 1'b0;
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (step) out_vld_d = 1'b1;
    else if (out_o.ready) out_vld_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // input register payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      action_q <= in_i.action;
      sample_q <= in_i.sample_value;
    end
  end

  // result register payload
  always_ff @(posedge clk_i) begin
    if (step) res_q <= res;
  end

  mslc_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (cfg_we_i),
    .idx_i  (cfg_idx_i),
    .data_i (cfg_data_i),
    .cfg_o  (cfg)
  );

  mslc_step u_step (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .cfg_i    (cfg),
    .action_i (action_q),
    .sample_i (sample_q),
    .res_o    (res)
  );

  assign out_o.valid      = out_vld_q;
  assign out_o.lamp_on    = res_q.lamp_on;
  assign out_o.mode       = res_q.mode;
  assign out_o.status_led = res_q.status_led;

endmodule

`default_nettype wire

// ===== hw/rtl/mslc_checker.sv =====
// port-level checks on the lamp controller result channel, bound to the top
// depends on mslc_pkg for mode codes
`default_nettype none

module mslc_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid_i,
  input wire logic       out_ready_i,
  input wire logic       lamp_on_i,
  input wire logic [1:0] mode_i,
  input wire logic       status_led_i
);

  // a stalled result beat keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(lamp_on_i) && $stable(mode_i) && $stable(status_led_i))
    else $error("result beat changed while stalled");

  // sleep always has the lamp off
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && mode_i == mslc_pkg::MODE_SLEEP |-> !lamp_on_i)
    else $error("lamp on in sleep");

  // on mode always drives the lamp
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && mode_i == mslc_pkg::MODE_ON |-> lamp_on_i)
    else $error("lamp off in on mode");

  // idle always shows the indicator high
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && mode_i == mslc_pkg::MODE_IDLE |-> status_led_i)
    else $error("status led low in idle");

endmodule

bind motion_sound_lamp_controller mslc_checker u_mslc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .lamp_on_i    (out_o.lamp_on),
  .mode_i       (out_o.mode),
  .status_led_i (out_o.status_led)
);

`default_nettype wire

// ===== verif/tb_motion_sound_lamp_controller.sv =====
// self-checking bench for the street lamp controller: directed table, then random phases
// depends on mslc_pkg, mslc_in_if, mslc_out_if and motion_sound_lamp_controller
`default_nettype none

module tb_motion_sound_lamp_controller;
  import mslc_pkg::*;

  localparam int CYCLE_LIMIT   = 500000;
  localparam int SETTLE_CYCLES = 4;
  localparam int LONG_HOLD     = 80;
  localparam int RAND_PHASES   = 4;
  localparam int PHASE_ITEMS   = 300;
  localparam int PLAN_ROWS     = 37;

  // action code the block must ignore
  localparam logic [ActW-1:0] ACT_INVALID = 2'd3;

  typedef enum logic [2:0] {
    EVT_NONE   = 3'd0,
    EVT_TIMER  = 3'd1,
    EVT_MOTION = 3'd2,
    EVT_SOUND  = 3'd3,
    EVT_SLEEP  = 3'd4
  } lamp_evt_e;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

  typedef struct {
    row_kind_e           kind;
    logic [CfgIdxW-1:0]  reg_idx;
    logic [CfgDataW-1:0] reg_data;
    logic [ActW-1:0]     act;
    logic [SampleW-1:0]  smp;
    bit                  typed;
    result_t             want;
  } lamp_row_t;

  localparam result_t NO_RES = '{1'b0, MODE_IDLE, 1'b0};

  // directed plan: reset state, extremes of threshold and tick registers, zero registers,
  // sleep handling, invalid action, escalation from on to alarm
  lamp_row_t plan [PLAN_ROWS] = '{
    '{ROW_ITEM, CFG_SOUND_THR,  16'd0,     ACT_TICK,    12'h000, 1'b1, '{1'b0, MODE_IDLE,  1'b1}},
    '{ROW_ITEM, CFG_SOUND_THR,  16'd0,     ACT_INVALID, 12'h000, 1'b1, '{1'b0, MODE_IDLE,  1'b1}},
    '{ROW_ITEM, CFG_SOUND_THR,  16'd0,     ACT_SOUND,   12'h000, 1'b0, NO_RES},
    '{ROW_ITEM, CFG_SOUND_THR,  16'd0,     ACT_SOUND,   12'hFFF, 1'b1, '{1'b0, MODE_IDLE,  1'b1}},
    '{ROW_ITEM, CFG_SOUND_THR,  16'd0,     ACT_MOTION,  12'h000, 1'b1, '{1'b1, MODE_ALARM, 1'b1}},
    '{ROW_ITEM, CFG_SOUND_THR,  16'd0,     ACT_MOTION,  12'hFFF, 1'b0, NO_RES},
    '{ROW_ITEM, CFG_SOUND_THR,  16'd0,     ACT_SOUND,   12'hFFF, 1'b0, NO_RES},
    '{ROW_CFG,  CFG_SOUND_THR,  16'd255,   ACT_TICK,    12'h000, 1'b0, NO_RES},
    '{ROW_CFG,  CFG_ON_TIMEOUT, 16'd2,     ACT_TICK,    12'h000, 1'b0, NO_RES},
    '{ROW_CFG,  CFG_SOUND_HOLD, 16'd1,     ACT_TICK,    12'h000, 1'b0, NO_RES},
    '{ROW_CFG,  CFG_IDLE_SLEEP, 16'd1,     ACT_TICK,    12'h000, 1'b0, NO_RES},
    '{ROW_CFG,  CFG_BLINK,      16'd1,     ACT_TICK,    12'h000, 1'b0, NO_RES},
    '{ROW_ITEM, CFG_SOUND_THR,  16'd0,     ACT_TICK,    12'h000, 1'b0, NO_RES},
    '{ROW_ITEM, CFG_SOUND_THR,  16'd0,     ACT_TICK,    12'hFFF, 1'b0, NO_RES},
    '{ROW_ITEM, CFG_SOUND_THR,  16'd0,     ACT_SOUND,   12'hFFF, 1'b0, NO_RES},
    '{ROW_ITEM, CFG_SOUND_THR,  16'd0,     ACT_TICK,    12'h000, 1'b0, NO_RES},
    '{ROW_ITEM, CFG_SOUND_THR,  16'd0,     ACT_TICK,    12'h000, 1'b0, NO_RES},
    '{ROW_ITEM, CFG_SOUND_THR,  16'd0,     ACT_SOUND,   12'hFFF, 1'b0, NO_RES},
    '{ROW_ITEM, CFG_SOUND_THR,  16'd0,     ACT_INVALID, 12'h5A5, 1'b0, NO_RES},
    '{ROW_ITEM, CFG_SOUND_THR,  16'd0,     ACT_MOTION,  12'h000, 1'b1, '{1'b0, MODE_IDLE,  1'b1}},
    '{ROW_CFG,  CFG_SOUND_THR,  16'd0,     ACT_TICK,    12'h000, 1'b0, NO_RES},
    '{ROW_CFG,  CFG_ON_TIMEOUT, 16'd0,     ACT_TICK,    12'h000, 1'b0, NO_RES},
    '{ROW_CFG,  CFG_BLINK,      16'd0,     ACT_TICK,    12'h000, 1'b0, NO_RES},
    '{ROW_CFG,  CFG_SOUND_HOLD, 16'hFFFF,  ACT_TICK,    12'h000, 1'b0, NO_RES},
    '{ROW_CFG,  CFG_IDLE_SLEEP, 16'hFFFF,  ACT_TICK,    12'h000, 1'b0, NO_RES},
    '{ROW_ITEM, CFG_SOUND_THR,  16'd0,     ACT_SOUND,   12'h010, 1'b0, NO_RES},
    '{ROW_ITEM, CFG_SOUND_THR,  16'd0,     ACT_MOTION,  12'h000, 1'b1, '{1'b1, MODE_ALARM, 1'b1}},
    '{ROW_ITEM, CFG_SOUND_THR,  16'd0,     ACT_TICK,    12'h000, 1'b0, NO_RES},
    '{ROW_ITEM, CFG_SOUND_THR,  16'd0,     ACT_SOUND,   12'h00F, 1'b0, NO_RES},
    '{ROW_CFG,  CFG_SOUND_THR,  16'd128,   ACT_TICK,    12'h000, 1'b0, NO_RES},
    '{ROW_CFG,  CFG_ON_TIMEOUT, 16'hFFFF,  ACT_TICK,    12'h000, 1'b0, NO_RES},
    '{ROW_CFG,  CFG_SOUND_HOLD, 16'd3,     ACT_TICK,    12'h000, 1'b0, NO_RES},
    '{ROW_ITEM, CFG_SOUND_THR,  16'd0,     ACT_MOTION,  12'h000, 1'b1, '{1'b1, MODE_ON,    1'b1}},
    '{ROW_ITEM, CFG_SOUND_THR,  16'd0,     ACT_SOUND,   12'h810, 1'b1, '{1'b1, MODE_ALARM, 1'b0}},
    '{ROW_ITEM, CFG_SOUND_THR,  16'd0,     ACT_SOUND,   12'h80F, 1'b0, NO_RES},
    '{ROW_ITEM, CFG_SOUND_THR,  16'd0,     ACT_MOTION,  12'h000, 1'b0, NO_RES},
    '{ROW_ITEM, CFG_SOUND_THR,  16'd0,     ACT_TICK,    12'h000, 1'b0, NO_RES}
  };

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  mslc_in_if  lamp_in ();
  mslc_out_if lamp_out ();

  motion_sound_lamp_controller dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (lamp_in),
    .out_o      (lamp_out),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  // lamp model state and register copy
  cfg_t            m_cfg;
  mode_e           m_mode;
  lamp_evt_e       m_event;
  logic [CntW-1:0] m_timeout_cnt, m_idle_cnt, m_hold_cnt, m_blink_cnt;
  logic            m_sound_recent, m_blink_en, m_lamp, m_led;

  result_t lamp_expect_q [$];
  result_t oldest_res;
  int      mismatch_count = 0;
  int      cycle_count = 0;

  // pacing state of the stimulus and result side; sink_steady and hold_asks pass between them
  bit      sink_steady = 1'b0;
  bit      src_steady = 1'b0;
  int      hold_asks = 0;
  int      hold_served = 0;
  int      hold_left = 0;
  int      stall_left = 0;

  // result beat seen during the last cycle
  bit          out_beat = 1'b0;
  logic        out_lamp;
  logic [1:0]  out_mode;
  logic        out_led;

  function automatic logic [CntW-1:0] count_up(input logic [CntW-1:0] c);
    return (c == '1) ? c : c + CntW'(1);
  endfunction

  // timer and sleep overwrite the slot, the others only fill it when empty
  function automatic void post_event(input lamp_evt_e e);
    if (e == EVT_TIMER || e == EVT_SLEEP || m_event == EVT_NONE) m_event = e;
  endfunction

  function automatic void enter_idle();
    m_mode     = MODE_IDLE;
    m_idle_cnt = '0;
    m_led      = 1'b1;
  endfunction

  function automatic void switch_mode(input mode_e next);
    // leave the current mode
    if (m_mode == MODE_ON) begin
      m_led = 1'b0;
      if (next == MODE_IDLE) m_lamp = 1'b0;
    end else if (m_mode == MODE_ALARM) begin
      m_led      = 1'b0;
      m_blink_en = 1'b0;
      m_lamp     = 1'b0;
    end
    // enter the next one
    case (next)
      MODE_IDLE: enter_idle();
      MODE_ON: begin
        m_mode        = MODE_ON;
        m_idle_cnt    = '0;
        m_lamp        = 1'b1;
        m_timeout_cnt = '0;
      end
      MODE_ALARM: begin
        m_mode         = MODE_ALARM;
        m_idle_cnt     = '0;
        m_sound_recent = 1'b0;
        m_hold_cnt     = '0;
        m_blink_en     = 1'b1;
        m_blink_cnt    = '0;
        m_timeout_cnt  = '0;
        m_lamp         = 1'b1;
      end
      default: begin
        m_mode = MODE_SLEEP;
        m_lamp = 1'b0;
      end
    endcase
  endfunction

  // apply one input beat to the lamp model and return the outputs after it
  function automatic result_t advance_lamp_model(input logic [ActW-1:0] act,
                                                 input logic [SampleW-1:0] smp);
    if (m_mode == MODE_SLEEP) begin
      if (act == ACT_MOTION) begin
        m_led         = 1'b1;
        m_timeout_cnt = '0;
        enter_idle();
      end
    end else begin
      case (act)
        ACT_TICK: begin
          m_timeout_cnt = count_up(m_timeout_cnt);
          if (m_timeout_cnt >= m_cfg.on_timeout) begin
            m_timeout_cnt = '0;
            post_event(EVT_TIMER);
          end
          if (m_sound_recent) begin
            m_hold_cnt = count_up(m_hold_cnt);
            if (m_hold_cnt >= m_cfg.sound_hold) begin
              m_hold_cnt     = '0;
              m_sound_recent = 1'b0;
            end
          end
          if (m_mode == MODE_ALARM && m_blink_en) begin
            m_blink_cnt = count_up(m_blink_cnt);
            if (m_blink_cnt >= m_cfg.blink) begin
              m_blink_cnt = '0;
              m_lamp      = ~m_lamp;
            end
          end
          if (m_mode == MODE_IDLE) begin
            m_idle_cnt = count_up(m_idle_cnt);
            if (m_idle_cnt >= m_cfg.idle_sleep) begin
              m_idle_cnt = '0;
              post_event(EVT_SLEEP);
            end
          end
        end
        ACT_MOTION: begin
          m_led = 1'b1;
          post_event(EVT_MOTION);
        end
        ACT_SOUND: begin
          if (smp[SampleW-1:4] > m_cfg.sound_thr) begin
            m_sound_recent = 1'b1;
            m_hold_cnt     = '0;
            if (m_mode != MODE_ALARM) post_event(EVT_SOUND);
          end
        end
        default: ;
      endcase

      // settle on the pending event; unhandled events stay in the slot
      case (m_mode)
        MODE_IDLE: begin
          m_led = 1'b1;
          case (m_event)
            EVT_MOTION: begin
              m_event = EVT_NONE;
              switch_mode(m_sound_recent ? MODE_ALARM : MODE_ON);
            end
            EVT_SOUND, EVT_TIMER: m_event = EVT_NONE;
            EVT_SLEEP: begin
              m_event = EVT_NONE;
              switch_mode(MODE_SLEEP);
            end
            default: ;
          endcase
        end
        MODE_ON: begin
          case (m_event)
            EVT_MOTION: begin
              m_timeout_cnt = '0;
              m_event       = EVT_NONE;
            end
            EVT_SOUND: begin
              m_event = EVT_NONE;
              switch_mode(MODE_ALARM);
            end
            EVT_TIMER: begin
              m_event = EVT_NONE;
              switch_mode(MODE_IDLE);
            end
            default: ;
          endcase
        end
        MODE_ALARM: begin
          case (m_event)
            EVT_MOTION: begin
              m_timeout_cnt = '0;
              m_event       = EVT_NONE;
            end
            EVT_TIMER: begin
              m_event = EVT_NONE;
              switch_mode(MODE_IDLE);
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end
    return '{lamp_on: m_lamp, mode: m_mode, status_led: m_led};
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return 0;
    else if (roll < 92) return $urandom_range(1, 3);
    else return $urandom_range(8, 40);
  endfunction

  // tick registers: mostly small so the timers fire often, sometimes zero or extreme
  function automatic logic [TickW-1:0] pick_tick_reg();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return TickW'($urandom_range(1, 8));
    else if (roll < 80) return '0;
    else if (roll < 88) return '1;
    else return TickW'($urandom_range(1, 65535));
  endfunction

  // present one input beat, wait for it to be taken, record what it should produce
  task automatic send_beat(input logic [ActW-1:0] act, input logic [SampleW-1:0] smp,
                           input bit typed, input result_t want);
    bit      took;
    result_t guess;
    lamp_in.valid        <= 1'b1;
    lamp_in.action       <= act;
    lamp_in.sample_value <= smp;
    do begin
      @(negedge clk_i);
      took = (lamp_in.ready === 1'b1);
      @(posedge clk_i);
    end while (!took);
    guess = advance_lamp_model(act, smp);
    lamp_expect_q.push_back(typed ? want : guess);
  endtask

  task automatic pace_source();
    int gap;
    gap = pick_gap();
    if (gap != 0) begin
      lamp_in.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // stop offering beats until every result is back, then let the pipeline empty
  task automatic wait_drained();
    lamp_in.valid <= 1'b0;
    while (lamp_expect_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_lamp_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    case (idx)
      CFG_SOUND_THR:  m_cfg.sound_thr  = data[ThrW-1:0];
      CFG_ON_TIMEOUT: m_cfg.on_timeout = data[TickW-1:0];
      CFG_SOUND_HOLD: m_cfg.sound_hold = data[TickW-1:0];
      CFG_IDLE_SLEEP: m_cfg.idle_sleep = data[TickW-1:0];
      CFG_BLINK:      m_cfg.blink      = data[TickW-1:0];
      default: ;
    endcase
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // snapshot the result channel mid-cycle, away from the clock edge
  always @(negedge clk_i) begin
    out_beat = (lamp_out.valid === 1'b1) && (lamp_out.ready === 1'b1);
    out_lamp = lamp_out.lamp_on;
    out_mode = lamp_out.mode;
    out_led  = lamp_out.status_led;
  end

  // result side: check each beat against the oldest expectation, then pace ready
  always @(posedge clk_i) begin
    if (out_beat) begin
      if (lamp_expect_q.size() == 0) begin
        $error("result beat with no expectation waiting");
        mismatch_count++;
      end else begin
        oldest_res = lamp_expect_q.pop_front();
        if (out_lamp !== oldest_res.lamp_on) begin
          $error("lamp_on: expected %0d, got %0d", oldest_res.lamp_on, out_lamp);
          mismatch_count++;
        end
        if (out_mode !== oldest_res.mode) begin
          $error("mode: expected %0d, got %0d", oldest_res.mode, out_mode);
          mismatch_count++;
        end
        if (out_led !== oldest_res.status_led) begin
          $error("status_led: expected %0d, got %0d", oldest_res.status_led, out_led);
          mismatch_count++;
        end
      end
    end

    if (hold_left > 0) begin
      hold_left--;
      lamp_out.ready <= 1'b0;
    end else if (hold_asks != hold_served) begin
      hold_served++;
      hold_left = LONG_HOLD - 1;
      lamp_out.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      lamp_out.ready <= 1'b0;
    end else if (sink_steady || $urandom_range(0, 7) != 0) begin
      lamp_out.ready <= 1'b1;
    end else begin
      stall_left = pick_gap();
      lamp_out.ready <= 1'b0;
    end
  end

  // stimulus
  initial begin
    int              i;
    int              phase;
    int              roll;
    logic [ActW-1:0] act;
    logic [SampleW-1:0] smp;
    logic [ThrW-1:0] thr;

    lamp_in.valid        <= 1'b0;
    lamp_in.action       <= ACT_TICK;
    lamp_in.sample_value <= '0;
    cfg_we_i             <= 1'b0;
    cfg_idx_i            <= CFG_SOUND_THR;
    cfg_data_i           <= '0;

    // model starts from the reset state
    m_cfg          = '{RST_SOUND_THR, RST_ON_TIMEOUT, RST_SOUND_HOLD, RST_IDLE_SLEEP, RST_BLINK};
    m_mode         = MODE_IDLE;
    m_event        = EVT_NONE;
    m_timeout_cnt  = '0;
    m_idle_cnt     = '0;
    m_hold_cnt     = '0;
    m_blink_cnt    = '0;
    m_sound_recent = 1'b0;
    m_blink_en     = 1'b0;
    m_lamp         = 1'b0;
    m_led          = 1'b0;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    for (i = 0; i < PLAN_ROWS; i++) begin
      if (plan[i].kind == ROW_CFG) begin
        wait_drained();
        write_lamp_reg(plan[i].reg_idx, plan[i].reg_data);
      end else begin
        send_beat(plan[i].act, plan[i].smp, plan[i].typed, plan[i].want);
        pace_source();
      end
    end

    // random phases, each with fresh register settings; phase 1 has a steady receiver, phase 2 a steady sender
    for (phase = 0; phase < RAND_PHASES; phase++) begin
      wait_drained();
      sink_steady = (phase == 1);
      src_steady  = (phase == 2);
      roll = $urandom_range(0, 99);
      thr  = (roll < 15) ? 8'd0 : (roll < 30) ? 8'd255 : ThrW'($urandom_range(0, 255));
      write_lamp_reg(CFG_SOUND_THR, CfgDataW'(thr));
      write_lamp_reg(CFG_ON_TIMEOUT, pick_tick_reg());
      write_lamp_reg(CFG_SOUND_HOLD, pick_tick_reg());
      write_lamp_reg(CFG_IDLE_SLEEP, pick_tick_reg());
      write_lamp_reg(CFG_BLINK, pick_tick_reg());

      for (i = 0; i < PHASE_ITEMS; i++) begin
        // long receiver hold-off while beats keep coming, and one full pause of the sender
        if (phase == 1 && i == 100) hold_asks++;
        if (phase == 2 && i == 150) wait_drained();

        roll = $urandom_range(0, 99);
        act  = (roll < 45) ? ACT_TICK : (roll < 65) ? ACT_MOTION :
               (roll < 92) ? ACT_SOUND : ACT_INVALID;
        // half the samples sit right at the loudness threshold
        if ($urandom_range(0, 1) != 0)
          smp = {m_cfg.sound_thr + ThrW'($urandom_range(0, 1)), 4'($urandom_range(0, 15))};
        else
          smp = SampleW'($urandom_range(0, 4095));
        send_beat(act, smp, 1'b0, NO_RES);
        if (!src_steady) pace_source();
      end
    end

    wait_drained();
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
